@@ rtl/core/bsfs_pkg.sv @@
// ----------------------------------------------------------------------------
// bsfs_pkg: shared definitions for the byte stream frame splitter
// Hold store sizing, mark bounds, register indexes, config bundle, FSM states.
// ----------------------------------------------------------------------------
`default_nettype none

package bsfs_pkg;

  // Hold store depth and the widest mark that may be used
  localparam int HOLD_DEPTH = 64;
  localparam int MARK_MAX   = 4;

  // Mark compare is limited by the 4-byte recent window as well
  localparam int MARK_LIM = (MARK_MAX < 4) ? MARK_MAX : 4;

  // Store address and held count widths
  localparam int ADDR_W = $clog2(HOLD_DEPTH);
  localparam int CNT_W  = $clog2(HOLD_DEPTH + 1);

  // Config port widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes on the config port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE       = 3'd0,
    REG_FIXED_MODE   = 3'd1,
    REG_FRAME_LENGTH = 3'd2,
    REG_MARK_BYTES   = 3'd3,
    REG_MARK_LENGTH  = 3'd4,
    REG_MAX_HOLD     = 3'd5
  } cfg_reg_t;

  // Current configuration as seen by the framing logic
  typedef struct packed {
    logic        enable;
    logic        fixed_mode;
    logic [6:0]  frame_length;
    logic [31:0] mark_bytes;
    logic [2:0]  mark_length;
    logic [6:0]  max_hold;
  } cfg_t;

  // Framing sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PASS,
    ST_EMIT
  } fsm_t;

endpackage

`default_nettype wire

@@ rtl/core/bsfs_ram.sv @@
// ----------------------------------------------------------------------------
// bsfs_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bsfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/bsfs_cfg.sv @@
// ----------------------------------------------------------------------------
// bsfs_cfg: configuration register file
// Decodes indexed writes into the framing registers; always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module bsfs_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output      logic                             cfg_ready,
  input  wire logic [bsfs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bsfs_pkg::CFG_DATA_W-1:0]  cfg_data,
  output      bsfs_pkg::cfg_t                   cfg
);

  assign cfg_ready = 1'b1;

  // Register writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable       <= 1'b0;
      cfg.fixed_mode   <= 1'b0;
      cfg.frame_length <= 7'd8;
      cfg.mark_bytes   <= 32'd0;
      cfg.mark_length  <= 3'd0;
      cfg.max_hold     <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bsfs_pkg::REG_ENABLE:       cfg.enable       <= cfg_data[0];
        bsfs_pkg::REG_FIXED_MODE:   cfg.fixed_mode   <= cfg_data[0];
        bsfs_pkg::REG_FRAME_LENGTH: cfg.frame_length <= cfg_data[6:0];
        bsfs_pkg::REG_MARK_BYTES:   cfg.mark_bytes   <= cfg_data[31:0];
        bsfs_pkg::REG_MARK_LENGTH:  cfg.mark_length  <= cfg_data[2:0];
        bsfs_pkg::REG_MAX_HOLD:     cfg.max_hold     <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/byte_stream_frame_splitter.sv @@
// ----------------------------------------------------------------------------
// byte_stream_frame_splitter: fixed length / delimiter framer for a byte stream
// Held bytes live in a circular hold RAM; completed frames are read back out.
//
//   channel  | signals                                      | direction
//   ---------+----------------------------------------------+----------
//   bytes    | byte_valid, byte_stall, data_byte            | in
//   frames   | frame_valid, frame_stall, out_byte, frame_end| out
//   config   | cfg_valid, cfg_ready, cfg_index, cfg_data    | in
//
// A byte is taken whenever the sequencer is idle, also while a result waits
// in the output register. A pass-through byte is held and loaded into the
// output register from the PASS state once that register is free; the input
// stalls until then, so the next byte is not taken before it is loaded.
// Frame bytes are read from the RAM with one read in flight, so a read is
// issued only after the last read's byte has gone into the output register.
// Reset clears control state only; the hold RAM has no clearing pass.
// Stall on the frame side freezes the output register and holds back reads.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_stream_frame_splitter (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Byte requests
  input  wire logic                             byte_valid,
  output      logic                             byte_stall,
  input  wire logic [7:0]                       data_byte,
  // Frame requests
  output      logic                             frame_valid,
  input  wire logic                             frame_stall,
  output      logic [7:0]                       out_byte,
  output      logic                             frame_end,
  // Config writes
  input  wire logic                             cfg_valid,
  output      logic                             cfg_ready,
  input  wire logic [bsfs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bsfs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = bsfs_pkg::ADDR_W;
  localparam int CW = bsfs_pkg::CNT_W;

  bsfs_pkg::cfg_t cfg;

  // Sequencer and hold store bookkeeping
  bsfs_pkg::fsm_t state, state_next;
  logic [AW-1:0]  head, head_next;
  logic [CW-1:0]  count, count_next;
  logic [CW-1:0]  fcnt, fcnt_next;
  logic [31:0]    win, win_next;
  logic           pend, pend_next;
  logic           pend_end, pend_end_next;
  logic [7:0]     pass_byte, pass_byte_next;
  logic           load_pass;

  // RAM ports
  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_waddr;
  logic [7:0]     ram_rdata;

  // Derived quantities
  logic [CW:0]    wsum;
  logic [CW-1:0]  n;
  logic [6:0]     n7;
  logic [6:0]     fl;
  logic [6:0]     limit;
  logic [2:0]     mlen;
  logic [31:0]    new_win;
  logic           match;
  logic           full;
  logic           out_free;
  logic [CW-1:0]  count_dec;
  logic [AW-1:0]  head_inc;
  logic           fixed_end;

  bsfs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bsfs_ram #(
    .WIDTH (8),
    .DEPTH (bsfs_pkg::HOLD_DEPTH)
  ) u_hold_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (data_byte),
    .re    (ram_re),
    .raddr (head),
    .rdata (ram_rdata)
  );

  // Tail address of the circular store
  assign wsum      = (CW+1)'(head) + (CW+1)'(count);
  assign ram_waddr = (wsum >= (CW+1)'(bsfs_pkg::HOLD_DEPTH))
                   ? AW'(wsum - (CW+1)'(bsfs_pkg::HOLD_DEPTH)) : AW'(wsum);
  assign head_inc  = (head == AW'(bsfs_pkg::HOLD_DEPTH - 1)) ? '0 : head + AW'(1);

  assign full      = (count == CW'(bsfs_pkg::HOLD_DEPTH));
  assign n         = count + CW'(1);
  assign n7        = 7'(n);
  assign count_dec = count - CW'(1);

  // Effective frame length, hold limit and mark length
  assign fl    = (cfg.frame_length == 7'd0) ? 7'd1 : cfg.frame_length;
  assign limit = (cfg.max_hold > 7'(bsfs_pkg::HOLD_DEPTH))
               ? 7'(bsfs_pkg::HOLD_DEPTH) : cfg.max_hold;
  assign mlen  = (cfg.mark_length > 3'(bsfs_pkg::MARK_LIM))
               ? 3'(bsfs_pkg::MARK_LIM) : cfg.mark_length;

  // Window with the new byte and the mark compare over the used bytes
  assign new_win = {win[23:0], data_byte};

  always_comb begin
    match = 1'b1;
    for (int k = 0; k < 4; k++) begin
      if ((3'(k) < mlen) && (new_win[8*k +: 8] != cfg.mark_bytes[8*k +: 8])) begin
        match = 1'b0;
      end
    end
  end

  assign out_free   = !frame_valid || !frame_stall;
  assign fixed_end  = ((7'(fcnt) + 7'd1) == fl);
  assign byte_stall = (state != bsfs_pkg::ST_IDLE);

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsfs_pkg::ST_IDLE;
      count <= '0;
      head  <= '0;
      win   <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      head  <= head_next;
      win   <= win_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    fcnt      <= fcnt_next;
    pend_end  <= pend_end_next;
    pass_byte <= pass_byte_next;
  end

  // Next state: accept, append or pass through, and decide; then stream frames out of the RAM
  always_comb begin
    state_next     = state;
    head_next      = head;
    count_next     = count;
    fcnt_next      = fcnt;
    win_next       = win;
    pend_next      = 1'b0;
    pend_end_next  = pend_end;
    pass_byte_next = pass_byte;
    load_pass      = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;

    unique case (state)
      bsfs_pkg::ST_IDLE: begin
        if (byte_valid) begin
          if (!cfg.enable) begin
            pass_byte_next = data_byte;
            state_next     = bsfs_pkg::ST_PASS;
          end else if (full) begin
            // store full: drop buffer and byte
            count_next = '0;
            win_next   = '0;
          end else begin
            ram_we     = 1'b1;
            count_next = n;
            win_next   = new_win;
            if (cfg.fixed_mode) begin
              if (n7 >= fl) begin
                fcnt_next  = '0;
                state_next = bsfs_pkg::ST_EMIT;
              end else if (n7 > limit) begin
                count_next = '0;
                win_next   = '0;
              end
            end else begin
              if ((mlen == 3'd0) || ((n7 >= 7'(mlen)) && match)) begin
                fcnt_next  = '0;
                state_next = bsfs_pkg::ST_EMIT;
              end else if (n7 > limit) begin
                count_next = '0;
                win_next   = '0;
              end
            end
          end
        end
      end

      bsfs_pkg::ST_PASS: begin
        if (out_free && !pend) begin
          load_pass  = 1'b1;
          state_next = bsfs_pkg::ST_IDLE;
        end
      end

      bsfs_pkg::ST_EMIT: begin
        // one read in flight; issue when the output register will be free
        if (out_free && !pend) begin
          ram_re     = 1'b1;
          pend_next  = 1'b1;
          head_next  = head_inc;
          count_next = count_dec;
          if (cfg.fixed_mode) begin
            pend_end_next = fixed_end;
            fcnt_next     = fixed_end ? '0 : fcnt + CW'(1);
            if (fixed_end && (7'(count_dec) < fl)) begin
              state_next = bsfs_pkg::ST_IDLE;
              if (count_dec == '0) begin
                win_next = '0;
              end
            end
          end else begin
            pend_end_next = (count == CW'(1));
            if (count == CW'(1)) begin
              state_next = bsfs_pkg::ST_IDLE;
              win_next   = '0;
            end
          end
        end
      end

      default: state_next = bsfs_pkg::ST_IDLE;
    endcase
  end

  // Output register: RAM data or pass-through byte
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (pend || load_pass) begin
      frame_valid <= 1'b1;
    end else if (!frame_stall) begin
      frame_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend) begin
      out_byte  <= ram_rdata;
      frame_end <= pend_end;
    end else if (load_pass) begin
      out_byte  <= pass_byte;
      frame_end <= 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ bench/byte_stream_frame_splitter_tb.sv @@
// ----------------------------------------------------------------------------
// byte_stream_frame_splitter_tb: self-checking bench for the byte framer
// Drives bytes in random bursts, stalls the frame side on its own pattern and
// predicts every frame byte from a behavioral copy of the hold buffer. Runs a
// short directed pass over the corner cases, then randomized config phases.
// ----------------------------------------------------------------------------
module byte_stream_frame_splitter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS   = 280;
  localparam int QUIET_CYCLES   = 40;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int LIMIT_CYCLES   = 300000;

  // One byte of an emitted frame
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  // Behavioral framer plus the queue of frame bytes still owed by the block
  class split_scoreboard_t;
    logic              en;
    logic              fixed;
    logic [6:0]        flen;
    logic [31:0]       mbytes;
    logic [2:0]        mlen;
    logic [6:0]        maxh;
    logic [7:0]        store [bsfs_pkg::HOLD_DEPTH];
    int unsigned       held;
    logic [31:0]       window;
    frame_beat_t       frames_due[$];
    int                errors;

    function new();
      en     = 1'b0;
      fixed  = 1'b0;
      flen   = 7'd8;
      mbytes = '0;
      mlen   = '0;
      maxh   = 7'd64;
      held   = 0;
      window = '0;
      errors = 0;
    endfunction

    function void write_reg(bsfs_pkg::cfg_reg_t idx, logic [31:0] val);
      case (idx)
        bsfs_pkg::REG_ENABLE:       en     = val[0];
        bsfs_pkg::REG_FIXED_MODE:   fixed  = val[0];
        bsfs_pkg::REG_FRAME_LENGTH: flen   = val[6:0];
        bsfs_pkg::REG_MARK_BYTES:   mbytes = val;
        bsfs_pkg::REG_MARK_LENGTH:  mlen   = val[2:0];
        bsfs_pkg::REG_MAX_HOLD:     maxh   = val[6:0];
        default: ;
      endcase
    endfunction

    function void drop_held();
      held   = 0;
      window = '0;
    endfunction

    // Queue cnt held bytes starting at from as one frame
    function void queue_run(int unsigned from, int unsigned cnt);
      int unsigned i;
      frame_beat_t beat;
      for (i = 0; i < cnt; i++) begin
        beat.data = store[(from + i) % bsfs_pkg::HOLD_DEPTH];
        beat.last = (i + 1 == cnt);
        frames_due.push_back(beat);
      end
    endfunction

    // Frame one accepted byte
    function void take_byte(logic [7:0] b);
      int unsigned n, fl, pos, len, lim, i;
      logic [31:0] mask;
      frame_beat_t beat;
      if (!en) begin
        beat.data = b;
        beat.last = 1'b1;
        frames_due.push_back(beat);
        return;
      end
      // store full: the byte and the buffer are lost
      if (held >= bsfs_pkg::HOLD_DEPTH) begin
        drop_held();
        return;
      end
      store[held] = b;
      n = held + 1;
      held = n;
      window = {window[23:0], b};
      if (fixed) begin
        fl = (flen == 0) ? 1 : int'(flen);
        pos = 0;
        while (n - pos >= fl) begin
          queue_run(pos, fl);
          pos += fl;
        end
        if (pos > 0) begin
          for (i = 0; i < n - pos; i++) store[i] = store[pos + i];
          held = n - pos;
          if (held == 0) window = '0;
          return;
        end
      end else begin
        len = int'(mlen);
        if (len > bsfs_pkg::MARK_LIM) len = bsfs_pkg::MARK_LIM;
        // empty mark: whole buffer leaves at once
        if (len == 0) begin
          queue_run(0, n);
          drop_held();
          return;
        end
        if (n >= len) begin
          mask = (len >= 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * len)) - 32'd1);
          if ((window & mask) == (mbytes & mask)) begin
            queue_run(0, n);
            drop_held();
            return;
          end
        end
      end
      // a frame completing on this byte wins over the hold limit
      lim = int'(maxh);
      if (lim > bsfs_pkg::HOLD_DEPTH) lim = bsfs_pkg::HOLD_DEPTH;
      if (n > lim) drop_held();
    endfunction

    function void check_out_byte(logic [7:0] data, logic last);
      frame_beat_t beat;
      if (frames_due.size() == 0) begin
        errors++;
        $display("%0t: frame byte expected none actual %02h end %0b", $time, data, last);
        return;
      end
      beat = frames_due.pop_front();
      if (data !== beat.data) begin
        errors++;
        $display("%0t: out_byte expected %02h actual %02h", $time, beat.data, data);
      end
      if (last !== beat.last) begin
        errors++;
        $display("%0t: frame_end expected %0b actual %0b", $time, beat.last, last);
      end
    endfunction

    function int pending();
      return frames_due.size();
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            byte_valid = 1'b0;
  logic                            byte_stall;
  logic [7:0]                      data_byte = '0;
  logic                            frame_valid;
  logic                            frame_stall = 1'b0;
  logic [7:0]                      out_byte;
  logic                            frame_end;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [bsfs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [bsfs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  split_scoreboard_t sb;
  int              items_sent = 0;
  int              burst_left = 0;
  int              holdoff_asked = 0;
  int              holdoff_seen = 0;
  int              hold_left = 0;
  int              rx_mode = 0;
  int              rx_left = 0;
  int              cycle_count = 0;
  logic [31:0]     mark_cfg = '0;
  int unsigned     mark_len_cfg = 0;

  byte_stream_frame_splitter u_top (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .data_byte   (data_byte),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .out_byte    (out_byte),
    .frame_end   (frame_end),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #4 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[byte_stream_frame_splitter] ERROR");
      $finish;
    end
  end

  // Frame side: check accepted bytes, stall on a pattern, long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      frame_stall <= 1'b0;
    end else begin
      if (frame_valid && !frame_stall) sb.check_out_byte(out_byte, frame_end);
      if (holdoff_seen != holdoff_asked) begin
        holdoff_seen++;
        hold_left = HOLDOFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        frame_stall <= 1'b1;
      end else begin
        if (rx_left == 0) begin
          rx_mode = $urandom_range(0, 2);
          rx_left = $urandom_range(5, 60);
        end
        rx_left--;
        case (rx_mode)
          0:       frame_stall <= 1'b0;
          1:       frame_stall <= ($urandom_range(0, 3) == 0);
          default: frame_stall <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  // Config write; random junk above the field width half the time
  task automatic write_reg(bsfs_pkg::cfg_reg_t idx, logic [31:0] val);
    logic [31:0] keep;
    logic [31:0] word;
    case (idx)
      bsfs_pkg::REG_ENABLE, bsfs_pkg::REG_FIXED_MODE:     keep = 32'h1;
      bsfs_pkg::REG_FRAME_LENGTH, bsfs_pkg::REG_MAX_HOLD: keep = 32'h7F;
      bsfs_pkg::REG_MARK_LENGTH:                          keep = 32'h7;
      default:                                            keep = 32'hFFFF_FFFF;
    endcase
    word = (val & keep);
    if ($urandom_range(0, 1) == 1) word = word | ($urandom & ~keep);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= word;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, word);
    if (idx == bsfs_pkg::REG_MARK_BYTES) mark_cfg = word;
    if (idx == bsfs_pkg::REG_MARK_LENGTH) mark_len_cfg = int'(word[2:0]);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // One byte request; idles between bursts of random length
  task automatic push_byte(logic [7:0] b);
    byte_valid <= 1'b1;
    data_byte  <= b;
    do @(posedge clk); while (byte_stall);
    sb.take_byte(b);
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50)
                                               : $urandom_range(1, 10);
    end
  endtask

  // Stop sending until every frame byte is out, then let the block settle
  task automatic wait_quiet();
    byte_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic set_fixed(logic [6:0] flen_v, logic [6:0] hold_v);
    write_reg(bsfs_pkg::REG_ENABLE, 32'd1);
    write_reg(bsfs_pkg::REG_FIXED_MODE, 32'd1);
    write_reg(bsfs_pkg::REG_FRAME_LENGTH, {25'd0, flen_v});
    write_reg(bsfs_pkg::REG_MAX_HOLD, {25'd0, hold_v});
  endtask

  task automatic set_mark(logic [31:0] mark_v, logic [2:0] len_v, logic [6:0] hold_v);
    write_reg(bsfs_pkg::REG_ENABLE, 32'd1);
    write_reg(bsfs_pkg::REG_FIXED_MODE, 32'd0);
    write_reg(bsfs_pkg::REG_MARK_BYTES, mark_v);
    write_reg(bsfs_pkg::REG_MARK_LENGTH, {29'd0, len_v});
    write_reg(bsfs_pkg::REG_MAX_HOLD, {25'd0, hold_v});
  endtask

  // Random body then the mark; now and then a cut mark or none
  task automatic send_mark_frame();
    int unsigned r, body, len, keep, j;
    r = $urandom_range(0, 19);
    body = (r < 16) ? $urandom_range(0, 8) :
           (r < 19) ? $urandom_range(9, 40) : $urandom_range(41, 70);
    len = (mark_len_cfg > bsfs_pkg::MARK_LIM) ? bsfs_pkg::MARK_LIM : mark_len_cfg;
    r = $urandom_range(0, 19);
    if (r < 17) keep = len;
    else if (r < 19 && len > 0) keep = $urandom_range(0, len - 1);
    else keep = 0;
    repeat (body) push_byte(8'($urandom));
    for (j = 0; j < keep; j++) push_byte(mark_cfg[8 * (len - 1 - j) +: 8]);
  endtask

  // Stimulus
  initial begin
    int          phase;
    int          start_cnt;
    int          ph_start;
    int unsigned r;
    logic [6:0]  flen_v;
    logic [6:0]  hold_v;
    logic [2:0]  len_v;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // pass-through after reset, byte extremes
    push_byte(8'h00);
    push_byte(8'hFF);

    // delimiter mode with an empty mark: each byte is a frame
    wait_quiet();
    write_reg(bsfs_pkg::REG_ENABLE, 32'd1);
    push_byte(8'h5A);
    push_byte(8'hA5);

    // fixed frames of three, then frame length zero acting as one
    wait_quiet();
    set_fixed(7'd3, 7'd64);
    push_byte(8'h01);
    push_byte(8'h02);
    push_byte(8'h03);
    wait_quiet();
    write_reg(bsfs_pkg::REG_FRAME_LENGTH, 32'd0);
    push_byte(8'h80);

    // hold five bytes, lower the length: several frames leave on one byte
    wait_quiet();
    write_reg(bsfs_pkg::REG_FRAME_LENGTH, 32'd10);
    repeat (5) push_byte(8'($urandom));
    wait_quiet();
    write_reg(bsfs_pkg::REG_FRAME_LENGTH, 32'd2);
    push_byte(8'h7E);

    // two-byte line mark, then an out-of-range mark length acting as four
    wait_quiet();
    set_mark(32'h0000_0D0A, 3'd2, 7'd64);
    push_byte(8'h41);
    push_byte(8'h0D);
    push_byte(8'h0A);
    wait_quiet();
    set_mark(32'hDEAD_BEEF, 3'd7, 7'd64);
    push_byte(8'hDE);
    push_byte(8'hAD);
    push_byte(8'hBE);
    push_byte(8'hEF);

    // hold limit zero drops non-completing bytes; completion beats the limit
    wait_quiet();
    set_mark(32'h0000_0055, 3'd1, 7'd0);
    push_byte(8'h12);
    push_byte(8'h55);
    wait_quiet();
    write_reg(bsfs_pkg::REG_MAX_HOLD, 32'd2);
    push_byte(8'h01);
    push_byte(8'h02);
    push_byte(8'h55);

    // randomized phases; held bytes carry over each mode change
    phase = 0;
    start_cnt = items_sent;
    while (items_sent - start_cnt < RANDOM_ITEMS) begin
      wait_quiet();
      case (phase % 5)
        0: begin
          // pass-through under a long hold-off so the input backs up
          write_reg(bsfs_pkg::REG_ENABLE, 32'd0);
          holdoff_asked++;
          burst_left = 1000;
          repeat (40) push_byte(8'($urandom));
          burst_left = 0;
          repeat (10) push_byte(8'($urandom));
        end
        1: begin
          r = $urandom_range(0, 9);
          flen_v = (r == 0) ? 7'd0 : (r == 1) ? 7'd64 :
                   (r == 2) ? 7'($urandom_range(65, 127)) : 7'($urandom_range(1, 12));
          r = $urandom_range(0, 9);
          hold_v = (r == 0) ? 7'd0 : (r == 1) ? 7'd127 :
                   (r == 2) ? 7'd64 : 7'($urandom_range(1, 64));
          set_fixed(flen_v, hold_v);
          repeat (30) push_byte(8'($urandom));
        end
        3: begin
          // frames never complete: the store fills and overflows
          set_fixed(7'($urandom_range(65, 127)), 7'($urandom_range(64, 127)));
          repeat ($urandom_range(66, 80)) push_byte(8'($urandom));
        end
        default: begin
          r = $urandom_range(0, 9);
          len_v = (r == 0) ? 3'd0 : (r == 1) ? 3'($urandom_range(5, 7)) :
                  3'($urandom_range(1, 4));
          r = $urandom_range(0, 9);
          hold_v = (r == 0) ? 7'd0 : (r == 1) ? 7'd127 : 7'($urandom_range(16, 64));
          set_mark($urandom, len_v, hold_v);
          ph_start = items_sent;
          while (items_sent - ph_start < 30) send_mark_frame();
        end
      endcase
      phase++;
    end

    wait_quiet();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[byte_stream_frame_splitter] OK");
    end else begin
      $display("[byte_stream_frame_splitter] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/bsfs_pkg.sv
rtl/core/bsfs_ram.sv
rtl/core/bsfs_cfg.sv
rtl/core/byte_stream_frame_splitter.sv
bench/byte_stream_frame_splitter_tb.sv
